// ===== rtl/ace_pkg.sv =====
package ace_pkg;

  // Attribute masks are fixed at 26 bits wide.
  localparam int ATTR_W         = 26;
  localparam int MAX_ATTRIBUTES = 26;
  localparam int CFG_W          = 5;
  localparam int OP_W           = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_tab;
    logic append;
    logic load_query;
    logic issue;
    logic restart;
    logic load_out;
  } ace_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic grew;
    logic full;
  } ace_sts_t;

  // Mask of the attributes in use. A count of zero means one attribute, and
  // counts above the maximum saturate.
  function automatic logic [ATTR_W-1:0] in_use_mask(input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0]  eff;
    logic [ATTR_W-1:0] m;
    eff = n;
    if (eff == '0) begin
      eff = CFG_W'(1);
    end
    if (eff > CFG_W'(MAX_ATTRIBUTES)) begin
      eff = CFG_W'(MAX_ATTRIBUTES);
    end
    for (int i = 0; i < ATTR_W; i++) begin
      m[i] = (CFG_W'(i) < eff);
    end
    return m;
  endfunction

endpackage

// ===== rtl/ace_ctrl.sv =====
module ace_ctrl
  import ace_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] op,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  ace_sts_t        sts,
  output ace_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SWEEP = 5'b00010,
    S_LAST  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (op)
            OP_CLEAR:  cmd.clear_tab = 1'b1;
            OP_APPEND: cmd.append    = 1'b1;
            OP_QUERY: begin
              cmd.load_query = 1'b1;
              state_nxt      = sts.count_zero ? S_DONE : S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.grew && !sts.full) begin
          cmd.restart = 1'b1;
          state_nxt   = S_SWEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/ace_datapath.sv =====
module ace_datapath
  import ace_pkg::*;
#(
  parameter int MAX_DEPENDENCIES = 64,
  parameter int AW               = 6,
  parameter int CNT_W            = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ace_cmd_t          cmd,
  output ace_sts_t          sts,
  input  logic [ATTR_W-1:0] full_mask,
  input  logic [ATTR_W-1:0] dep_left,
  input  logic [ATTR_W-1:0] dep_right,
  input  logic [ATTR_W-1:0] query_set,
  output logic [ATTR_W-1:0] closure_set,
  output logic              superkey_flag,
  output logic [CNT_W-1:0]  dependency_count,
  output logic              overflow_flag
);

  logic [ATTR_W-1:0] left_mem  [MAX_DEPENDENCIES];
  logic [ATTR_W-1:0] right_mem [MAX_DEPENDENCIES];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic              rd_valid_r;
  logic [ATTR_W-1:0] rd_left_r, rd_right_r;
  logic [ATTR_W-1:0] clo_r, clo_nxt;
  logic              grew_r, grew_nxt;
  logic [ATTR_W-1:0] out_clo_r;
  logic              out_sk_r, out_ovf_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              table_full;
  logic [ATTR_W-1:0] l_m, r_m, new_bits;

  assign table_full = (count_r == CNT_W'(MAX_DEPENDENCIES));

  // A dependency fires when its left side is inside the closure.
  assign l_m      = rd_left_r & full_mask;
  assign r_m      = rd_right_r & full_mask;
  assign new_bits = ((l_m & ~clo_r) == '0) ? (r_m & ~clo_r) : '0;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    clo_nxt   = clo_r;
    grew_nxt  = grew_r;
    if (cmd.clear_tab) begin
      count_nxt = '0;
    end
    if (cmd.append) begin
      if (table_full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (rd_valid_r) begin
      clo_nxt  = clo_r | new_bits;
      grew_nxt = grew_r | (|new_bits);
    end
    if (cmd.issue) begin
      k_nxt = k_r + AW'(1);
    end
    if (cmd.load_query) begin
      clo_nxt  = query_set & full_mask;
      grew_nxt = 1'b0;
      k_nxt    = '0;
    end
    if (cmd.restart) begin
      grew_nxt = 1'b0;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      rd_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    clo_r  <= clo_nxt;
    grew_r <= grew_nxt;
    if (cmd.load_out) begin
      out_clo_r <= clo_r;
      out_sk_r  <= (clo_r == full_mask);
      out_cnt_r <= count_r;
      out_ovf_r <= ovf_r;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append && !table_full) begin
      left_mem[count_r[AW-1:0]]  <= dep_left;
      right_mem[count_r[AW-1:0]] <= dep_right;
    end
    rd_left_r  <= left_mem[k_r];
    rd_right_r <= right_mem[k_r];
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.last_issue = (CNT_W'(k_r) == (count_r - CNT_W'(1)));
  assign sts.grew       = grew_r;
  assign sts.full       = (clo_r == full_mask);

  assign closure_set      = out_clo_r;
  assign superkey_flag    = out_sk_r;
  assign dependency_count = out_cnt_r;
  assign overflow_flag    = out_ovf_r;

endmodule

// ===== rtl/attribute_closure_engine_core.sv =====
// Clear and append transactions give no result.
// A query over N stored entries (N > 0) needs R table sweeps, R at most the
// attribute count; over an empty table it gives its result without a sweep.
// Input waits until the result is loaded into the output register, and
// longer while an earlier result is still held. Synchronous active-low reset
// empties the table, clears the overflow flag and sets the attribute count to 26.
module attribute_closure_engine_core
  import ace_pkg::*;
#(
  parameter int MAX_DEPENDENCIES = 64
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_tvalid,
  output logic             in_tready,
  // Bits from the lowest: dep_left[25:0], dep_right[51:26],
  // query_set[77:52], zero fill[79:78].
  input  logic [79:0]      in_tdata,
  // Bits from the lowest: operation[1:0].
  input  logic [OP_W-1:0]  in_tuser,

  output logic             out_tvalid,
  input  logic             out_tready,
  // Bits from the lowest: closure_set[25:0], superkey_flag[26],
  // dependency_count[26+CNT_W:27], overflow_flag, then zero fill.
  output logic [((ATTR_W + $clog2(MAX_DEPENDENCIES + 1) + 2 + 7) / 8) * 8 - 1:0] out_tdata,

  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CNT_W = $clog2(MAX_DEPENDENCIES + 1);
  localparam int OUT_W = ((ATTR_W + CNT_W + 2 + 7) / 8) * 8;
  localparam int AW    = (MAX_DEPENDENCIES > 1) ? $clog2(MAX_DEPENDENCIES) : 1;

  // Register index of attribute_count; byte address 4 * index.
  localparam logic REG_ATTR_CNT = 1'b0;

  localparam logic [CFG_W-1:0] ATTR_CNT_RESET = CFG_W'(26);

  logic [CFG_W-1:0]  attr_cnt_r;
  logic [ATTR_W-1:0] full_mask;
  logic              cfg_wr;

  ace_cmd_t          cmd;
  ace_sts_t          sts;

  logic [ATTR_W-1:0] closure_set;
  logic              superkey_flag;
  logic [CNT_W-1:0]  dependency_count;
  logic              overflow_flag;

  // The configuration port never stalls. The word index is address bit 2;
  // the two low address bits are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_cnt_r <= ATTR_CNT_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_ATTR_CNT)) begin
      attr_cnt_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_ATTR_CNT) ? {{(32-CFG_W){1'b0}}, attr_cnt_r}
                                                      : '0;

  // Attributes in use, with the count clamped to the valid range. The user
  // must change the attribute count only while the block is idle, which the
  // block itself does not enforce; then every stage of a query sees the same mask.
  assign full_mask = in_use_mask(attr_cnt_r);

  // The controller sequences the table sweeps and owns both handshakes.
  ace_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the dependency table, the growing closure and the
  // output register that keeps a result until the result transaction ends.
  ace_datapath #(
    .MAX_DEPENDENCIES(MAX_DEPENDENCIES),
    .AW              (AW),
    .CNT_W           (CNT_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .full_mask       (full_mask),
    .dep_left        (in_tdata[ATTR_W-1:0]),
    .dep_right       (in_tdata[2*ATTR_W-1:ATTR_W]),
    .query_set       (in_tdata[3*ATTR_W-1:2*ATTR_W]),
    .closure_set     (closure_set),
    .superkey_flag   (superkey_flag),
    .dependency_count(dependency_count),
    .overflow_flag   (overflow_flag)
  );

  assign out_tdata = {{(OUT_W-ATTR_W-CNT_W-2){1'b0}}, overflow_flag, dependency_count,
                      superkey_flag, closure_set};

endmodule
